// ===== sv/field_oriented_mecanum_mixer_assert.svh =====
// Assertion helpers shared by the mixer RTL.
`ifndef FIELD_ORIENTED_MECANUM_MIXER_ASSERT_SVH
`define FIELD_ORIENTED_MECANUM_MIXER_ASSERT_SVH

// Property checked at every rising edge outside of reset.
`define FOMM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// Property checked at every rising edge, reset included.
`define FOMM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fomm_pkg.sv =====
package fomm_pkg;

    // Turret encoder and phase format.
    localparam int ENCODER_COUNTS = 8192;
    localparam int TURRET_BITS    = $clog2(ENCODER_COUNTS);
    localparam int PHASE_BITS     = 16;
    localparam int PHASE_SHIFT    = PHASE_BITS - TURRET_BITS;
    localparam int QUARTER_TURN   = 16384;

    // Sine polynomial: angle in Q14, terms and result in Q15, each product rounded.
    localparam int TRIG_BITS = 16;
    localparam int Q14_BITS  = 14;
    localparam int X_BITS    = 15;
    localparam int Q14_ONE   = 16384;
    localparam int Q14_HALF  = 8192;
    localparam int SIN_C1    = 2320;
    localparam int SIN_C2    = 21024;
    localparam int SIN_C3    = 51472;
    localparam int Q15_MAX   = 32767;

    // Rotation result is scaled back from Q15.
    localparam int ROT_SHIFT  = 15;
    localparam int ROUND_HALF = 16384;

    // Mixed speeds carry eight fraction bits.
    localparam int MIX_SHIFT = 8;
    localparam int RPM_HALF  = 32768;
    localparam int Q16_BITS  = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_DATA_BITS-1:0] LEVER_RESET = 16'd256;
    localparam logic [CFG_DATA_BITS-1:0] RPM_RESET   = 16'd256;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_YAW_ZERO_COUNT,
        REG_WHEEL_LEVER,
        REG_SPEED_TO_RPM
    } cfg_reg_t;

    localparam int OPCODE_BITS = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ZERO_FORCE,
        OP_BODY_FRAME,
        OP_TURRET_FRAME
    } opcode_t;

    // Pipeline stage map.
    localparam int SINE_STAGES  = 5;
    localparam int ST_PROD      = 5;
    localparam int ST_ROT       = 6;
    localparam int ST_MIX       = 7;
    localparam int ST_WHEEL     = 8;
    localparam int WHEEL_STAGES = 3;
    localparam int NUM_STAGES   = ST_WHEEL + WHEEL_STAGES;

endpackage

// ===== sv/fomm_sine.sv =====
module fomm_sine (
    input  logic                                  aclk,
    input  logic [fomm_pkg::SINE_STAGES-1:0]      stage_en,
    input  logic [fomm_pkg::PHASE_BITS-1:0]       phase,
    output logic signed [fomm_pkg::TRIG_BITS-1:0] sine
);
    import fomm_pkg::*;

    // Quadrant folding, then an odd polynomial in the folded angle.
    logic [1:0]          quad;
    logic [Q14_BITS-1:0] frac;
    logic [X_BITS-1:0]   x_next;
    logic [30:0]         sq_full;
    logic [X_BITS-1:0]   x2_next;
    logic [27:0]         m1;
    logic [14:0]         t2_next;
    logic [30:0]         m2;
    logic [15:0]         t3_next;
    logic [31:0]         m3;
    logic [17:0]         c3;
    logic [14:0]         mag;
    logic signed [TRIG_BITS-1:0] sine_next;

    logic [X_BITS-1:0]   x_reg   [0:SINE_STAGES-2];
    logic                neg_reg [0:SINE_STAGES-2];
    logic [X_BITS-1:0]   x2_reg  [1:2];
    logic [14:0]         t2_reg;
    logic [15:0]         t3_reg;
    logic signed [TRIG_BITS-1:0] sine_reg;

    assign quad = phase[PHASE_BITS-1:PHASE_BITS-2];
    assign frac = phase[Q14_BITS-1:0];
    assign x_next = quad[0] ? X_BITS'(Q14_ONE) - X_BITS'(frac) : X_BITS'(frac);

    assign sq_full = 31'(x_reg[0]) * 31'(x_reg[0]) + 31'(Q14_HALF);
    assign x2_next = sq_full[28:14];

    assign m1      = 28'(SIN_C1) * 28'(x2_reg[1]) + 28'(Q14_HALF);
    assign t2_next = 15'(SIN_C2) - 15'(m1[27:14]);

    assign m2      = 31'(t2_reg) * 31'(x2_reg[2]) + 31'(Q14_HALF);
    assign t3_next = 16'(SIN_C3) - 16'(m2[30:14]);

    assign m3  = 32'(t3_reg) * 32'(x_reg[3]) + 32'(Q14_HALF);
    assign c3  = m3[31:14];
    assign mag = (c3 > 18'(Q15_MAX)) ? 15'(Q15_MAX) : c3[14:0];
    assign sine_next = neg_reg[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x_reg[0]   <= x_next;
            neg_reg[0] <= quad[1];
        end
        for (int i = 1; i < SINE_STAGES - 1; i++) begin
            if (stage_en[i]) begin
                x_reg[i]   <= x_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
        if (stage_en[1]) begin
            x2_reg[1] <= x2_next;
        end
        if (stage_en[2]) begin
            x2_reg[2] <= x2_reg[1];
            t2_reg    <= t2_next;
        end
        if (stage_en[3]) begin
            t3_reg <= t3_next;
        end
        if (stage_en[4]) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

// ===== sv/fomm_wheel.sv =====
module fomm_wheel #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic [fomm_pkg::WHEEL_STAGES-1:0]    stage_en,
    input  logic signed [SPEED_WIDTH+17:0]       mix,
    input  logic [fomm_pkg::CFG_DATA_BITS-1:0]   rpm_scale,
    output logic signed [SPEED_WIDTH-1:0]        wheel
);
    import fomm_pkg::*;

    localparam int MIX_W = SPEED_WIDTH + 18;

    // Magnitude times the Q8.8 factor, split at bit 16 into a high and a low product.
    logic [MIX_W-1:0]       mag_next;
    logic [32:0]            lo_round;
    logic [MIX_W:0]         total;
    logic [MIX_W:0]         limit;
    logic [MIX_W:0]         mag_sat;
    logic [SPEED_WIDTH-1:0] mag_out;
    logic signed [SPEED_WIDTH-1:0] wheel_next;

    logic [MIX_W-1:0]       mag_reg;
    logic                   neg_reg [0:1];
    logic [MIX_W-1:0]       hi_reg;
    logic [31:0]            lo_reg;
    logic signed [SPEED_WIDTH-1:0] wheel_reg;

    assign mag_next = mix[MIX_W-1] ? MIX_W'(-mix) : MIX_W'(mix);

    assign lo_round = {1'b0, lo_reg} + 33'(RPM_HALF);
    assign total    = (MIX_W+1)'(hi_reg) + (MIX_W+1)'(lo_round[32:Q16_BITS]);

    // Negative results may reach one count further than positive ones.
    assign limit    = neg_reg[1] ? ((MIX_W+1)'(1) << (SPEED_WIDTH - 1))
                                 : ((MIX_W+1)'(1) << (SPEED_WIDTH - 1)) - (MIX_W+1)'(1);
    assign mag_sat  = (total > limit) ? limit : total;
    assign mag_out  = mag_sat[SPEED_WIDTH-1:0];
    assign wheel_next = neg_reg[1] ? -$signed(mag_out) : $signed(mag_out);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mag_reg    <= mag_next;
            neg_reg[0] <= mix[MIX_W-1];
        end
        if (stage_en[1]) begin
            hi_reg     <= MIX_W'(mag_reg[MIX_W-1:Q16_BITS]) * MIX_W'(rpm_scale);
            lo_reg     <= 32'(mag_reg[Q16_BITS-1:0]) * 32'(rpm_scale);
            neg_reg[1] <= neg_reg[0];
        end
        if (stage_en[2]) begin
            wheel_reg <= wheel_next;
        end
    end

    assign wheel = wheel_reg;

endmodule

// ===== sv/field_oriented_mecanum_mixer.sv =====
// Channel   Direction  Transfer payload
// s_        in         tdata: speed_x, speed_y, turn_rate, turret_count; tuser: opcode
// m_        out        tdata: wheel_zero .. wheel_three; tuser: motors_enabled
// cfg_      in         write enable, register index, write data (no read-back)
//
// One command transfer per clock is sustained while m_tready stays high. Each result
// passes through every stage in order and is offered on m_ from the last one.
// The pipeline holds the sine polynomial (four dependent multiplies, each in its
// own stage) followed by rotation, mixing and scaling.
// Reset clears every stage valid bit and loads the configuration defaults.
// Each stage stalls only when it is full and the stage after it cannot take its
// data, so empty stages fill while a finished result waits on m_tready.
`include "field_oriented_mecanum_mixer_assert.svh"

module field_oriented_mecanum_mixer #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic aclk,
    input  logic aresetn,

    // Configuration writes.
    input  logic                                 cfg_wen,
    input  logic [fomm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fomm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,

    // Command stream.
    input  logic s_tvalid,
    output logic s_tready,
    // Low bit up: speed_x, speed_y, turn_rate, turret_count, zero pad.
    input  logic [((3*SPEED_WIDTH+fomm_pkg::TURRET_BITS+7)/8)*8-1:0] s_tdata,
    // opcode.
    input  logic [fomm_pkg::OPCODE_BITS-1:0] s_tuser,

    // Wheel speed stream.
    output logic m_tvalid,
    input  logic m_tready,
    // Low bit up: wheel_zero, wheel_one, wheel_two, wheel_three, zero pad.
    output logic [((4*SPEED_WIDTH+7)/8)*8-1:0] m_tdata,
    // motors_enabled.
    output logic [0:0] m_tuser
);
    import fomm_pkg::*;

    localparam int W         = SPEED_WIDTH;
    localparam int M_TDATA_W = ((4*W+7)/8)*8;
    localparam int PROD_W    = W + TRIG_BITS;
    localparam int DIFF_W    = W + 17;
    localparam int ROT_W     = W + 2;
    localparam int BASE_W    = W + 17;
    localparam int MIX_W     = W + 18;

    // ------------------------------------------------------------------
    // Configuration registers. Writes arrive only while the pipeline is
    // empty, which the block does not enforce; stages read them directly.
    // ------------------------------------------------------------------
    logic [TURRET_BITS-1:0]   yaw_zero_reg;
    logic [CFG_DATA_BITS-1:0] lever_reg;
    logic [CFG_DATA_BITS-1:0] rpm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_zero_reg <= '0;
            lever_reg    <= LEVER_RESET;
            rpm_reg      <= RPM_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_YAW_ZERO_COUNT: yaw_zero_reg <= cfg_wdata[TURRET_BITS-1:0];
                REG_WHEEL_LEVER:    lever_reg    <= cfg_wdata;
                REG_SPEED_TO_RPM:   rpm_reg      <= cfg_wdata;
                default: begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake. A stage loads when it is empty or when the stage
    // after it loads in the same cycle; valid bits move with the data.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Input unpacking and opcode decode.
    // ------------------------------------------------------------------
    logic signed [W-1:0]    in_speed_x;
    logic signed [W-1:0]    in_speed_y;
    logic signed [W-1:0]    in_turn_rate;
    logic [TURRET_BITS-1:0] in_count;
    logic                   rot_next;
    logic                   ena_next;

    assign in_speed_x   = $signed(s_tdata[W-1:0]);
    assign in_speed_y   = $signed(s_tdata[2*W-1:W]);
    assign in_turn_rate = $signed(s_tdata[3*W-1:2*W]);
    assign in_count     = s_tdata[3*W+TURRET_BITS-1:3*W];

    // The reserved opcode behaves like zero force.
    always_comb begin
        unique case (opcode_t'(s_tuser))
            OP_BODY_FRAME: begin
                ena_next = 1'b1;
                rot_next = 1'b0;
            end
            OP_TURRET_FRAME: begin
                ena_next = 1'b1;
                rot_next = 1'b1;
            end
            default: begin
                ena_next = 1'b0;
                rot_next = 1'b0;
            end
        endcase
    end

    // Turret angle as a 16-bit fraction of a turn. The encoder wraps at a
    // power of two, so the offset subtraction wraps naturally.
    logic [TURRET_BITS-1:0] angle_idx;
    logic [PHASE_BITS-1:0]  sin_phase;
    logic [PHASE_BITS-1:0]  cos_phase;

    assign angle_idx = in_count - yaw_zero_reg;
    assign sin_phase = {angle_idx, {PHASE_SHIFT{1'b0}}};
    assign cos_phase = sin_phase + PHASE_BITS'(QUARTER_TURN);

    // ------------------------------------------------------------------
    // Stages 0 to 4: sine and cosine, with the commands carried alongside.
    // ------------------------------------------------------------------
    logic signed [TRIG_BITS-1:0] sin_q15;
    logic signed [TRIG_BITS-1:0] cos_q15;

    fomm_sine u_sin (
        .aclk     (aclk),
        .stage_en (stage_en[SINE_STAGES-1:0]),
        .phase    (sin_phase),
        .sine     (sin_q15)
    );

    fomm_sine u_cos (
        .aclk     (aclk),
        .stage_en (stage_en[SINE_STAGES-1:0]),
        .phase    (cos_phase),
        .sine     (cos_q15)
    );

    logic signed [W-1:0] vx_reg  [0:ST_PROD];
    logic signed [W-1:0] vy_reg  [0:ST_PROD];
    logic signed [W-1:0] w_reg   [0:ST_PROD-1];
    logic                rot_reg [0:ST_PROD];
    logic                ena_reg [0:NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            vx_reg[0]  <= in_speed_x;
            vy_reg[0]  <= in_speed_y;
            w_reg[0]   <= in_turn_rate;
            rot_reg[0] <= rot_next;
        end
        for (int i = 1; i <= ST_PROD; i++) begin
            if (stage_en[i]) begin
                vx_reg[i]  <= vx_reg[i-1];
                vy_reg[i]  <= vy_reg[i-1];
                rot_reg[i] <= rot_reg[i-1];
            end
        end
        for (int i = 1; i < ST_PROD; i++) begin
            if (stage_en[i]) begin
                w_reg[i] <= w_reg[i-1];
            end
        end
    end

    // The drive flag is control: it decides whether the wheels read zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                ena_reg[i] <= 1'b0;
            end
        end else begin
            if (stage_en[0]) begin
                ena_reg[0] <= ena_next;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    ena_reg[i] <= ena_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: rotation products and the lever term.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] pxc_reg;
    logic signed [PROD_W-1:0] pys_reg;
    logic signed [PROD_W-1:0] pxs_reg;
    logic signed [PROD_W-1:0] pyc_reg;
    logic signed [BASE_W-1:0] dw_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PROD]) begin
            pxc_reg <= PROD_W'(vx_reg[ST_PROD-1]) * PROD_W'(cos_q15);
            pys_reg <= PROD_W'(vy_reg[ST_PROD-1]) * PROD_W'(sin_q15);
            pxs_reg <= PROD_W'(vx_reg[ST_PROD-1]) * PROD_W'(sin_q15);
            pyc_reg <= PROD_W'(vy_reg[ST_PROD-1]) * PROD_W'(cos_q15);
            dw_reg  <= BASE_W'($signed({1'b0, lever_reg})) * BASE_W'(w_reg[ST_PROD-1]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: turret-frame speeds rotated and scaled back from Q15 with ties away from zero;
    // body-frame speeds pass unchanged. Adding one less than half before the arithmetic shift gives that
    // rounding for negative sums without taking a magnitude.
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] sum_y;
    logic signed [DIFF_W-1:0] rnd_x;
    logic signed [DIFF_W-1:0] rnd_y;
    logic signed [ROT_W-1:0]  rx_next;
    logic signed [ROT_W-1:0]  ry_next;
    logic signed [ROT_W-1:0]  rx_reg;
    logic signed [ROT_W-1:0]  ry_reg;
    logic signed [BASE_W-1:0] base_reg;

    assign diff_x = DIFF_W'(pxc_reg) - DIFF_W'(pys_reg);
    assign sum_y  = DIFF_W'(pxs_reg) + DIFF_W'(pyc_reg);
    assign rnd_x  = diff_x + (diff_x[DIFF_W-1] ? DIFF_W'(ROUND_HALF - 1)
                                               : DIFF_W'(ROUND_HALF));
    assign rnd_y  = sum_y + (sum_y[DIFF_W-1] ? DIFF_W'(ROUND_HALF - 1)
                                             : DIFF_W'(ROUND_HALF));

    assign rx_next = rot_reg[ST_PROD] ? $signed(rnd_x[DIFF_W-1:ROT_SHIFT])
                                      : ROT_W'(vx_reg[ST_PROD]);
    assign ry_next = rot_reg[ST_PROD] ? $signed(rnd_y[DIFF_W-1:ROT_SHIFT])
                                      : ROT_W'(vy_reg[ST_PROD]);

    always_ff @(posedge aclk) begin
        if (stage_en[ST_ROT]) begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            base_reg <= -dw_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: wheel mixing in units of 1/256. Zero force forces zero sums,
    // which the scaling stages turn into zero wheel speeds.
    // ------------------------------------------------------------------
    logic signed [MIX_W-1:0] mix_a;
    logic signed [MIX_W-1:0] mix_b;
    logic signed [MIX_W-1:0] mix_base;
    logic signed [MIX_W-1:0] mix_diff;
    logic signed [MIX_W-1:0] mix_sum;
    logic signed [MIX_W-1:0] mix_next [0:3];
    logic signed [MIX_W-1:0] mix_reg  [0:3];

    assign mix_a    = MIX_W'(rx_reg);
    assign mix_b    = MIX_W'(ry_reg);
    assign mix_base = MIX_W'(base_reg);
    assign mix_diff = (mix_a - mix_b) <<< MIX_SHIFT;
    assign mix_sum  = (mix_a + mix_b) <<< MIX_SHIFT;

    always_comb begin
        if (ena_reg[ST_ROT]) begin
            mix_next[0] = mix_base + mix_diff;
            mix_next[1] = mix_base - mix_sum;
            mix_next[2] = mix_base - mix_diff;
            mix_next[3] = mix_base + mix_sum;
        end else begin
            for (int k = 0; k < 4; k++) begin
                mix_next[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_MIX]) begin
            for (int k = 0; k < 4; k++) begin
                mix_reg[k] <= mix_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 8 to 10: rpm scaling and saturation, one unit per wheel.
    // ------------------------------------------------------------------
    logic signed [W-1:0] wheel [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_wheel
        fomm_wheel #(
            .SPEED_WIDTH (W)
        ) u_wheel (
            .aclk      (aclk),
            .stage_en  (stage_en[NUM_STAGES-1:ST_WHEEL]),
            .mix       (mix_reg[k]),
            .rpm_scale (rpm_reg),
            .wheel     (wheel[k])
        );
    end

    assign m_tdata = M_TDATA_W'({wheel[3], wheel[2], wheel[1], wheel[0]});
    assign m_tuser = ena_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `FOMM_ASSERT(a_zero_force_wheels, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "disabled result carries nonzero wheel speeds")
    `FOMM_ASSERT(a_stall_only_when_full, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled while the pipeline could still advance")
    `FOMM_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
